[src/bsvd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the barcode symbol value decoder.
package bsvd_pkg;

  localparam int unsigned CodeW = 7;
  localparam int unsigned CharW = 8;
  localparam int unsigned HeldN = 3;

  // symbol values with a fixed meaning
  localparam logic [CodeW-1:0] CV_SHIFT  = 7'd98;
  localparam logic [CodeW-1:0] CV_CODE_C = 7'd99;
  localparam logic [CodeW-1:0] CV_FNC4_B = 7'd100;
  localparam logic [CodeW-1:0] CV_FNC4_A = 7'd101;
  localparam logic [CodeW-1:0] CV_FNC1   = 7'd102;
  localparam logic [CodeW-1:0] CV_START_A = 7'd103;
  localparam logic [CodeW-1:0] CV_START_C = 7'd105;
  localparam logic [CodeW-1:0] CV_STOP   = 7'd106;

  localparam logic [CharW-1:0] CH_GS = 8'd29;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_FORMAT   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_CHAR   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // all results of one transaction
  typedef struct packed {
    logic [HeldN-1:0][CharW-1:0] chars;
    logic [1:0]                  nchar;
    logic                        has_status;
    status_e                     status;
  } bundle_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

endpackage

[src/bsvd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for symbol values and decoded results.
interface bsvd_code_if;
  logic       valid;
  logic       ready;
  logic [6:0] code_value;

  modport source (output valid, output code_value, input ready);
  modport sink (input valid, input code_value, output ready);
endinterface

interface bsvd_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_value;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output kind, output char_value, output status,
                  output last, input ready);
  modport sink (input valid, input kind, input char_value, input status,
                input last, output ready);
endinterface

[src/bsvd_decoder.sv]
`timescale 1ns / 1ps
// Symbol state tracking, character generation and mod-103 checksum.
module bsvd_decoder
  import bsvd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             gs1_mode_i,
  input  logic             code_valid_i,
  input  logic [CodeW-1:0] code_i,
  input  logic             advance_i,
  output logic             has_results_o,
  output bundle_t          bundle_o
);

  typedef enum logic [1:0] {
    SET_A = 2'd0,
    SET_B = 2'd1,
    SET_C = 2'd2
  } code_set_e;

  // x < 10609: floor(x * 10181 / 2^20) equals floor(x / 103)
  function automatic logic [6:0] mod103(input logic [13:0] x);
    logic [27:0] p;
    logic [6:0]  q;
    logic [13:0] r;
    p = 28'(x) * 28'd10181;
    q = p[26:20];
    r = x - 14'(q) * 14'd103;
    return r[6:0];
  endfunction

  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

  logic             in_symbol_q, in_symbol_d;
  code_set_e        code_set_q, code_set_d;
  logic             up_latch_q, up_latch_d;
  logic             up_shift_q, up_shift_d;
  logic             shift_pend_q, shift_pend_d;
  logic [6:0]       wsum_q, wsum_d;
  logic [6:0]       pos_q, pos_d;
  logic [6:0]       latest_q, latest_d;
  logic [13:0]      prod_q, prod_d;
  logic [1:0]       held_cnt_q, held_cnt_d;
  logic             held_prn_q, held_prn_d;
  logic             text_ne_q, text_ne_d;
  logic [CharW-1:0] held_q [HeldN];
  logic [CharW-1:0] held_d [HeldN];

  always_comb begin
    logic             tne;
    logic             is_a;
    logic             hold_up;
    logic             fnc1;
    logic             fnc4;
    logic [6:0]       base;
    logic [6:0]       pos_n;
    logic [3:0]       tens;
    logic [6:0]       ones;

    in_symbol_d  = in_symbol_q;
    code_set_d   = code_set_q;
    up_latch_d   = up_latch_q;
    up_shift_d   = up_shift_q;
    shift_pend_d = shift_pend_q;
    wsum_d       = wsum_q;
    pos_d        = pos_q;
    latest_d     = latest_q;
    prod_d       = prod_q;
    held_cnt_d   = held_cnt_q;
    held_prn_d   = held_prn_q;
    text_ne_d    = text_ne_q;
    for (int i = 0; i < HeldN; i++) begin
      held_d[i] = held_q[i];
      bundle_o.chars[i] = held_q[i];
    end
    bundle_o.nchar      = 2'd0;
    bundle_o.has_status = 1'b0;
    bundle_o.status     = ST_OK;

    tne     = text_ne_q | (held_cnt_q != 2'd0);
    is_a    = (code_set_q == SET_A);
    hold_up = 1'b0;
    fnc1    = 1'b0;
    fnc4    = 1'b0;
    base    = 7'd0;
    pos_n   = (pos_q >= 7'd103) ? 7'd1 : pos_q + 7'd1;
    tens    = div10(code_i);
    ones    = code_i - 7'(tens) * 7'd10;

    if (!in_symbol_q) begin
      if (code_i >= CV_START_A && code_i <= CV_START_C) begin
        in_symbol_d  = 1'b1;
        code_set_d   = code_set_e'(2'(code_i - CV_START_A));
        up_latch_d   = 1'b0;
        up_shift_d   = 1'b0;
        shift_pend_d = 1'b0;
        wsum_d       = code_i - CV_START_A;
        pos_d        = 7'd0;
        latest_d     = 7'd0;
        prod_d       = 14'd0;
        held_cnt_d   = 2'd0;
        held_prn_d   = 1'b0;
        text_ne_d    = 1'b0;
      end
    end else if (code_i == CV_STOP) begin
      bundle_o.has_status = 1'b1;
      if (wsum_q != latest_q) begin
        bundle_o.status = ST_CHECKSUM;
      end else if (!held_prn_q) begin
        bundle_o.nchar  = held_cnt_q;
        bundle_o.status = tne ? ST_OK : ST_EMPTY;
      end else begin
        bundle_o.status = text_ne_q ? ST_OK : ST_EMPTY;
      end
      in_symbol_d = 1'b0;
      held_cnt_d  = 2'd0;
    end else if (code_i >= CV_START_A) begin
      bundle_o.has_status = 1'b1;
      bundle_o.status     = ST_FORMAT;
      in_symbol_d         = 1'b0;
      held_cnt_d          = 2'd0;
    end else begin
      bundle_o.nchar = held_cnt_q;
      text_ne_d      = tne;
      wsum_d         = mod103(14'(wsum_q) + prod_q);
      pos_d          = pos_n;
      latest_d       = code_i;
      prod_d         = 14'(pos_n) * 14'(code_i);
      shift_pend_d   = 1'b0;
      held_prn_d     = 1'b0;
      held_cnt_d     = 2'd0;

      if (code_set_q == SET_A || code_set_q == SET_B) begin
        if (is_a && code_i < 7'd64) begin
          base    = code_i + 7'd32;
          hold_up = 1'b1;
        end else if (is_a && code_i < 7'd96) begin
          base    = code_i - 7'd64;
          hold_up = 1'b1;
        end else if (!is_a && code_i < 7'd96) begin
          base    = code_i + 7'd32;
          hold_up = 1'b1;
        end else if (code_i == CV_FNC1) begin
          fnc1 = 1'b1;
        end else if (code_i == CV_SHIFT) begin
          shift_pend_d = 1'b1;
          code_set_d   = is_a ? SET_B : SET_A;
        end else if (code_i == CV_CODE_C) begin
          code_set_d = SET_C;
        end else if (code_i == (is_a ? CV_FNC4_A : CV_FNC4_B)) begin
          fnc4 = 1'b1;
        end else if (code_i == CV_FNC4_A || code_i == CV_FNC4_B) begin
          code_set_d = is_a ? SET_B : SET_A;
        end
      end else begin
        if (code_i < 7'd100) begin
          held_d[0]  = 8'h30 + 8'(tens);
          held_d[1]  = 8'h30 + 8'(ones);
          held_cnt_d = 2'd2;
          held_prn_d = 1'b1;
        end else if (code_i == CV_FNC1) begin
          fnc1 = 1'b1;
        end else if (code_i == CV_FNC4_A) begin
          code_set_d = SET_A;
        end else begin
          code_set_d = SET_B;
        end
      end

      if (hold_up) begin
        held_d[0]  = {(up_shift_q != up_latch_q), base};
        held_cnt_d = 2'd1;
        held_prn_d = 1'b1;
        up_shift_d = 1'b0;
      end

      if (fnc4) begin
        if (up_shift_q) begin
          up_latch_d = !up_latch_q;
          up_shift_d = 1'b0;
        end else begin
          up_shift_d = 1'b1;
        end
      end

      if (fnc1 && gs1_mode_i) begin
        if (!tne) begin
          held_d[0]  = 8'h5D;
          held_d[1]  = 8'h43;
          held_d[2]  = 8'h31;
          held_cnt_d = 2'd3;
        end else begin
          held_d[0]  = CH_GS;
          held_cnt_d = 2'd1;
        end
      end

      if (shift_pend_q) begin
        code_set_d = (code_set_d == SET_A) ? SET_B : SET_A;
      end
    end
  end

  assign has_results_o = code_valid_i && (bundle_o.has_status || bundle_o.nchar != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_symbol_q  <= 1'b0;
      code_set_q   <= SET_A;
      up_latch_q   <= 1'b0;
      up_shift_q   <= 1'b0;
      shift_pend_q <= 1'b0;
      wsum_q       <= 7'd0;
      pos_q        <= 7'd0;
      latest_q     <= 7'd0;
      prod_q       <= 14'd0;
      held_cnt_q   <= 2'd0;
      held_prn_q   <= 1'b0;
      text_ne_q    <= 1'b0;
    end else if (advance_i) begin
      in_symbol_q  <= in_symbol_d;
      code_set_q   <= code_set_d;
      up_latch_q   <= up_latch_d;
      up_shift_q   <= up_shift_d;
      shift_pend_q <= shift_pend_d;
      wsum_q       <= wsum_d;
      pos_q        <= pos_d;
      latest_q     <= latest_d;
      prod_q       <= prod_d;
      held_cnt_q   <= held_cnt_d;
      held_prn_q   <= held_prn_d;
      text_ne_q    <= text_ne_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int i = 0; i < HeldN; i++) begin
        held_q[i] <= held_d[i];
      end
    end
  end

endmodule

[src/bsvd_serializer.sv]
`timescale 1ns / 1ps
// Result register that hands out a transaction's results one per cycle while the receiver is ready.
module bsvd_serializer
  import bsvd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  bundle_t   bundle_i,
  output ser_stat_t stat_o,
  bsvd_result_if.source result_out
);

  bundle_t    bundle_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic [2:0] last_idx;
  logic       is_char;
  logic       is_last;
  logic       pop;

  assign last_idx = 3'(bundle_q.nchar) + 3'(bundle_q.has_status) - 3'd1;
  assign is_char  = idx_q < bundle_q.nchar;
  assign is_last  = ({1'b0, idx_q} == last_idx);
  assign pop      = valid_q && result_out.ready;

  always_comb begin
    case (idx_q)
      2'd0:    result_out.char_value = bundle_q.chars[0];
      2'd1:    result_out.char_value = bundle_q.chars[1];
      2'd2:    result_out.char_value = bundle_q.chars[2];
      default: result_out.char_value = '0;
    endcase
    if (!is_char) begin
      result_out.char_value = '0;
    end
  end

  assign result_out.valid  = valid_q;
  assign result_out.kind   = is_char ? KIND_CHAR : KIND_STATUS;
  assign result_out.status = is_char ? ST_OK : bundle_q.status;
  assign result_out.last   = is_last;

  assign stat_o.busy = valid_q;
  assign stat_o.done = pop && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (pop && is_last) begin
      valid_q <= 1'b0;
    end else if (pop) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

[src/barcode_symbol_value_decoder_core.sv]
`timescale 1ns / 1ps
// Top level of the barcode symbol value decoder.
//
// Symbol values enter an input register; combinational decode logic updates the
// symbol state (code set, shifts, FNC4 latch, mod-103 checksum) and loads all
// results of that transaction into the output register, which hands them out
// one per cycle while the receiver is ready: up to three text characters
// followed, on a stop or a stray start value, by one status. A transaction
// holds the output until its last result leaves, so the input takes one
// value per cycle only while each yields at most one result and the output
// is ready. One value can be taken while a result waits at the output. The
// user must write gs1_mode with cfg_we_i only while no transaction is in
// flight; the block itself does not enforce this.
module barcode_symbol_value_decoder_core
  import bsvd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  bsvd_code_if.sink     code_in,
  bsvd_result_if.source result_out
);

  logic             gs1_mode_q;
  logic [CodeW-1:0] code_q;
  logic             code_valid_q;
  logic             has_results;
  logic             advance;
  logic             load;
  bundle_t          bundle;
  ser_stat_t        ser_stat;

  assign advance = code_valid_q && (!has_results || !ser_stat.busy || ser_stat.done);
  assign load    = advance && has_results;
  assign code_in.ready = !code_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs1_mode_q   <= 1'b0;
      code_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gs1_mode_q <= cfg_wdata_i;
      end
      if (code_in.valid && code_in.ready) begin
        code_valid_q <= 1'b1;
      end else if (advance) begin
        code_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_in.valid && code_in.ready) begin
      code_q <= code_in.code_value;
    end
  end

  bsvd_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gs1_mode_i    (gs1_mode_q),
    .code_valid_i  (code_valid_q),
    .code_i        (code_q),
    .advance_i     (advance),
    .has_results_o (has_results),
    .bundle_o      (bundle)
  );

  bsvd_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .bundle_i   (bundle),
    .stat_o     (ser_stat),
    .result_out (result_out)
  );

  // output register is only reloaded once its last result leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!ser_stat.busy || ser_stat.done))
    else $error("result bundle overwritten while results pending");

  // a held value stays put until the decoder takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_valid_q && !advance) |=> (code_valid_q && $stable(code_q)))
    else $error("pending symbol value lost");

  // after the final result of a transaction, output idles unless reloaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_stat.done && !load) |=> !result_out.valid)
    else $error("results repeated after last");

  // a status result always closes its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_out.valid && result_out.kind == KIND_STATUS) |-> result_out.last)
    else $error("status result not marked last");

endmodule
